// ===== rtl/dotted_label_name_checker_core_assert.svh =====
// ----------------------------------------------------------------------------
// Dotted label name checker assertion macros
// Shorthand for clocked concurrent assertions, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef DOTTED_LABEL_NAME_CHECKER_CORE_ASSERT_SVH
`define DOTTED_LABEL_NAME_CHECKER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DLNC_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DLNC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dlnc_pkg.sv =====
// ----------------------------------------------------------------------------
// Dotted label name checker package
// Character codes, limits and the byte class shared by the checker modules.
// ----------------------------------------------------------------------------
package dlnc_pkg;

    localparam logic [7:0] DOT_CODE    = 8'h2E;
    localparam logic [7:0] HYPHEN_CODE = 8'h2D;
    localparam logic [1:0] MIN_LABEL   = 2'd3;
    localparam logic [7:0] TOTAL_MAX   = 8'hFF;

    localparam logic [7:0] MIN_LENGTH_RESET = 8'd3;
    localparam logic [7:0] MAX_LENGTH_RESET = 8'd63;

    typedef enum logic
    {
        REG_MIN_LENGTH = 1'b0,
        REG_MAX_LENGTH = 1'b1
    } cfg_index_t;

    typedef struct packed
    {
        logic is_lower;
        logic let_dig;
        logic is_dot;
        logic is_hyphen;
    } char_class_t;

endpackage

// ===== rtl/dlnc_classify.sv =====
// ----------------------------------------------------------------------------
// Dotted label name checker byte classifier
// Sorts one byte into the character classes that the label grammar uses.
// ----------------------------------------------------------------------------
module dlnc_classify
    import dlnc_pkg::*;
(
    input  logic [7:0]  char_code,
    output char_class_t char_class
);

    logic lower;
    logic digit;

    always_comb
    begin
        lower = (char_code inside {[8'h61:8'h7A]});
        digit = (char_code inside {[8'h30:8'h39]});
        char_class.is_lower  = lower;
        char_class.let_dig   = lower | digit;
        char_class.is_dot    = (char_code == DOT_CODE);
        char_class.is_hyphen = (char_code == HYPHEN_CODE);
    end

endmodule

// ===== rtl/dotted_label_name_checker_core.sv =====
// Pipeline: a byte is classified into an input register, then updates the name
// state; the verdict for a last byte then goes into the result register.
// Throughput: one byte per cycle, limited only by the result register when a
// verdict waits to be taken. Reset clears all name state, the pipeline valids
// and restores min_length to 3 and max_length to 63.
// ----------------------------------------------------------------------------
// Dotted label name checker core
// Checks a byte stream name against a dot-separated label grammar and a
// configurable total length window, giving one verdict per name.
// ----------------------------------------------------------------------------
module dotted_label_name_checker_core
    import dlnc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_code,
    input  logic       last_char,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       name_ok
);

    `include "dotted_label_name_checker_core_assert.svh"

    char_class_t in_class;

    logic [7:0]  min_length_reg;
    logic [7:0]  max_length_reg;
    logic        s1_valid_reg;
    logic        s1_last_reg;
    char_class_t s1_class_reg;
    logic [7:0]  total_count_reg;
    logic [7:0]  total_count_next;
    logic [1:0]  label_count_reg;
    logic [1:0]  label_count_next;
    logic        prev_let_dig_reg;
    logic        error_seen_reg;
    logic        error_seen_next;
    logic        out_valid_reg;
    logic        name_ok_reg;
    logic        name_ok_next;
    logic        out_free;
    logic        s1_move;
    logic        in_accept;

    dlnc_classify u_classify
    (
        .char_code  (char_code),
        .char_class (in_class)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_move   = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_stall  = s1_valid_reg && !s1_move;
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign name_ok   = name_ok_reg;

    always_comb
    begin
        total_count_next = (total_count_reg == TOTAL_MAX) ? TOTAL_MAX
                                                           : total_count_reg + 8'd1;
        error_seen_next  = error_seen_reg;
        if (label_count_reg == 2'd0)
        begin
            if (!s1_class_reg.is_lower)
            begin
                error_seen_next = 1'b1;
            end
            label_count_next = 2'd1;
        end
        else if (s1_class_reg.is_dot)
        begin
            if ((label_count_reg < MIN_LABEL) || !prev_let_dig_reg)
            begin
                error_seen_next = 1'b1;
            end
            label_count_next = 2'd0;
        end
        else
        begin
            if (!s1_class_reg.let_dig && !s1_class_reg.is_hyphen)
            begin
                error_seen_next = 1'b1;
            end
            label_count_next = (label_count_reg < MIN_LABEL) ? label_count_reg + 2'd1
                                                              : label_count_reg;
        end
        name_ok_next = !error_seen_next && !s1_class_reg.is_dot && s1_class_reg.let_dig
                       && (label_count_next == MIN_LABEL)
                       && (total_count_next >= min_length_reg)
                       && (total_count_next <= max_length_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_length_reg   <= MIN_LENGTH_RESET;
            max_length_reg   <= MAX_LENGTH_RESET;
            s1_valid_reg     <= 1'b0;
            total_count_reg  <= 8'd0;
            label_count_reg  <= 2'd0;
            prev_let_dig_reg <= 1'b0;
            error_seen_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    REG_MIN_LENGTH: min_length_reg <= cfg_data;
                    REG_MAX_LENGTH: max_length_reg <= cfg_data;
                    default:        min_length_reg <= min_length_reg;
                endcase
            end
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                if (s1_last_reg)
                begin
                    total_count_reg  <= 8'd0;
                    label_count_reg  <= 2'd0;
                    prev_let_dig_reg <= 1'b0;
                    error_seen_reg   <= 1'b0;
                end
                else
                begin
                    total_count_reg  <= total_count_next;
                    label_count_reg  <= label_count_next;
                    prev_let_dig_reg <= s1_class_reg.let_dig;
                    error_seen_reg   <= error_seen_next;
                end
            end
            if (s1_move && s1_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_last_reg  <= last_char;
            s1_class_reg <= in_class;
        end
        if (s1_move && s1_last_reg)
        begin
            name_ok_reg <= name_ok_next;
        end
    end

    `DLNC_ASSERT_NEXT(a_last_clears_state, s1_move && s1_last_reg,
        (total_count_reg == 8'd0) && (label_count_reg == 2'd0) && !error_seen_reg,
        "name state not cleared after the last beat")
    `DLNC_ASSERT_NEXT(a_last_gives_result, s1_move && s1_last_reg, out_valid_reg,
        "no verdict after the last beat")
    `DLNC_ASSERT_SAME(a_stall_only_when_held, in_stall, s1_valid_reg && s1_last_reg,
        "input stalled without a pending last beat")
    `DLNC_ASSERT_NEXT(a_label_stays_open,
        s1_move && !s1_last_reg && !s1_class_reg.is_dot && (label_count_reg != 2'd0),
        label_count_reg != 2'd0,
        "label count dropped to zero without a dot")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dotted label name checker testbench
// Feeds names one byte per beat through the valid/stall input channel. A
// predictor in the testbench keeps its own copy of the name state and length
// limits and works out each verdict. Every verdict beat is checked against it.
// The run starts with directed names and limit settings, then moves on to
// random phases of mostly well-formed names. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb;
    import dlnc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int QUIET_FROM  = 400;
    localparam int QUIET_TO    = 900;
    localparam int DRAIN_WAIT  = 4;

    typedef struct
    {
        logic [7:0] code;
        logic       last;
    } name_beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    cfg_index_t cfg_index = REG_MIN_LENGTH;
    logic [7:0] cfg_data = 8'd0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] char_code = 8'd0;
    logic       last_char = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       name_ok;

    name_beat_t beat_q[$];
    logic [7:0] name_buf[$];
    logic       verdict_q[$];
    int         queued_cnt = 0;
    int         taken_cnt = 0;
    int         cycle_cnt = 0;
    int         err_cnt = 0;

    logic [7:0] lim_min = MIN_LENGTH_RESET;
    logic [7:0] lim_max = MAX_LENGTH_RESET;
    logic [7:0] tot_len = 8'd0;
    logic [1:0] lab_len = 2'd0;
    logic       prev_ld = 1'b0;
    logic       bad_seen = 1'b0;

    dotted_label_name_checker_core uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_code (char_code),
        .last_char (last_char),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .name_ok   (name_ok)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    function automatic logic take_break();
        if (cycle_cnt >= QUIET_FROM && cycle_cnt < QUIET_TO)
            return 1'b0;
        return $urandom_range(0, 99) < 23;
    endfunction

    function automatic void judge_byte(input logic [7:0] c, input logic last);
        logic lower;
        logic ld;
        lower = c >= 8'h61 && c <= 8'h7A;
        ld = lower || (c >= 8'h30 && c <= 8'h39);
        if (tot_len != TOTAL_MAX)
            tot_len = tot_len + 8'd1;
        if (lab_len == 2'd0)
        begin
            if (!lower)
                bad_seen = 1'b1;
            lab_len = 2'd1;
        end
        else if (c == DOT_CODE)
        begin
            if (lab_len < MIN_LABEL || !prev_ld)
                bad_seen = 1'b1;
            lab_len = 2'd0;
        end
        else
        begin
            if (!ld && c != HYPHEN_CODE)
                bad_seen = 1'b1;
            if (lab_len < MIN_LABEL)
                lab_len = lab_len + 2'd1;
        end
        prev_ld = ld;
        if (last)
        begin
            verdict_q.push_back(!bad_seen && c != DOT_CODE && ld && lab_len >= MIN_LABEL
                                && tot_len >= lim_min && tot_len <= lim_max);
            tot_len = 8'd0;
            lab_len = 2'd0;
            prev_ld = 1'b0;
            bad_seen = 1'b0;
        end
    endfunction

    // Input channel driver: a stalled beat is held until it is taken.
    always @(posedge clk)
    begin
        name_beat_t nxt;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                judge_byte(char_code, last_char);
                taken_cnt++;
            end
            if (!(in_valid && in_stall))
            begin
                if (beat_q.size() != 0 && !take_break())
                begin
                    nxt = beat_q.pop_front();
                    in_valid <= 1'b1;
                    char_code <= nxt.code;
                    last_char <= nxt.last;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        logic want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (verdict_q.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: unexpected verdict beat, expected none, actual name_ok %0b",
                             $time, name_ok);
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (name_ok !== want)
                    begin
                        err_cnt++;
                        $display("%0t: name_ok mismatch, expected %0b, actual %0b",
                                 $time, want, name_ok);
                    end
                end
            end
            out_stall <= take_break();
        end
    end

    initial
    begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("%0t: timeout with %0d verdicts outstanding", $time, verdict_q.size());
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [7:0] rand_lower();
        return 8'h61 + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_let_dig();
        if ($urandom_range(0, 3) == 0)
            return 8'h30 + 8'($urandom_range(0, 9));
        return rand_lower();
    endfunction

    function automatic logic [7:0] rand_inner();
        if ($urandom_range(0, 4) == 0)
            return HYPHEN_CODE;
        return rand_let_dig();
    endfunction

    task automatic add_label(input int n);
        for (int i = 0; i < n; i++)
        begin
            if (i == 0)
                name_buf.push_back(rand_lower());
            else if (i == n - 1)
                name_buf.push_back(rand_let_dig());
            else
                name_buf.push_back(rand_inner());
        end
    endtask

    // Builds a grammatical name of exactly len bytes; below three bytes
    // the single label is simply too short.
    task automatic make_name(input int len);
        int left;
        int lab;
        name_buf.delete();
        left = len;
        while (left > 0)
        begin
            if (left <= 12)
                lab = left;
            else
                lab = $urandom_range(3, (left - 4 < 10) ? left - 4 : 10);
            add_label(lab);
            left -= lab;
            if (left > 0)
            begin
                name_buf.push_back(DOT_CODE);
                left--;
            end
        end
    endtask

    task automatic mutate_name();
        int pos;
        pos = $urandom_range(0, name_buf.size() - 1);
        case ($urandom_range(0, 4))
            0: name_buf[pos] = 8'($urandom_range(0, 255));
            1: name_buf[pos] = DOT_CODE;
            2: name_buf[pos] = HYPHEN_CODE;
            3: name_buf[pos] = 8'h41 + 8'($urandom_range(0, 25));
            default: name_buf[pos] = 8'h30 + 8'($urandom_range(0, 9));
        endcase
    endtask

    task automatic queue_name();
        name_beat_t b;
        foreach (name_buf[i])
        begin
            b.code = name_buf[i];
            b.last = (i == name_buf.size() - 1);
            beat_q.push_back(b);
        end
        queued_cnt += name_buf.size();
    endtask

    task automatic queue_text(input string s);
        name_buf.delete();
        for (int i = 0; i < s.len(); i++)
            name_buf.push_back(s[i]);
        queue_name();
    endtask

    task automatic queue_good(input int len);
        make_name(len);
        queue_name();
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [7:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_MIN_LENGTH)
            lim_min = val;
        else
            lim_max = val;
    endtask

    task automatic drain();
        while (taken_cnt != queued_cnt || verdict_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic int pick_len();
        int base;
        case ($urandom_range(0, 9))
            0, 1: base = lim_min;
            2, 3: base = lim_max;
            default: return $urandom_range(1, 40);
        endcase
        base = base - 1 + $urandom_range(0, 2);
        return (base < 1) ? 1 : base;
    endfunction

    initial
    begin
        int phase_base;
        int kind;
        logic [7:0] lo;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        queue_text("abc");
        queue_text("a");
        queue_text(".abc");
        queue_text("abc..def");
        queue_text("abc.");
        queue_text("abc-");
        queue_text("a--z.b9z");
        queue_text("9ab");
        queue_text("aBc");
        queue_text("ab.cde");
        queue_text("abc-.def");
        queue_text("zz9.a-0");
        name_buf = '{8'h61, 8'hFF, 8'h62};
        queue_name();
        name_buf = '{8'h61, 8'h00, 8'h7A};
        queue_name();
        queue_good(64);
        drain();

        // A saturated length of 255 still fits a window that ends at 255.
        write_reg(REG_MIN_LENGTH, 8'd200);
        write_reg(REG_MAX_LENGTH, 8'd255);
        queue_good(256);
        drain();

        write_reg(REG_MIN_LENGTH, 8'd0);
        queue_text("abc");
        queue_text("ab");
        drain();

        write_reg(REG_MIN_LENGTH, 8'd100);
        write_reg(REG_MAX_LENGTH, 8'd50);
        queue_good(60);
        drain();

        write_reg(REG_MIN_LENGTH, 8'd3);
        write_reg(REG_MAX_LENGTH, 8'd3);
        queue_text("abc");
        queue_text("abcd");
        drain();

        for (int p = 0; p < 4; p++)
        begin
            lo = 8'($urandom_range(3, 30));
            write_reg(REG_MIN_LENGTH, lo);
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_MAX_LENGTH, 8'($urandom_range(3, 30)));
            else
                write_reg(REG_MAX_LENGTH, 8'($urandom_range(lo, 60)));
            phase_base = queued_cnt;
            while (queued_cnt - phase_base < 35)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 90)
                begin
                    make_name(pick_len());
                    if (kind >= 70)
                        mutate_name();
                end
                else
                begin
                    name_buf.delete();
                    repeat ($urandom_range(1, 12))
                        name_buf.push_back(8'($urandom_range(0, 255)));
                end
                queue_name();
            end
            drain();
        end

        if (verdict_q.size() != 0)
        begin
            err_cnt++;
            $display("%0t: %0d verdicts expected, none arrived", $time, verdict_q.size());
        end
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/dlnc_pkg.sv
rtl/dlnc_classify.sv
rtl/dotted_label_name_checker_core.sv
tb/tb.sv
